// ===== hw/rtl/plft_pkg.sv =====
// ----------------------------------------------------------------------------
// plft_pkg
// Shared types and constants of the parameter list fetch tracker.
// ----------------------------------------------------------------------------
package plft_pkg;

   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 3;
   localparam int PARAM_W    = 16;
   localparam int INDEX_OUT_W = 10;
   localparam int SEEN_OUT_W = 11;
   localparam int EXPECTED_W = 16;
   localparam int TIMEOUT_W  = 16;
   localparam int RETRY_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_PAD_W  = 2;

   // seen map and retry counters are stored in rows of this many slots
   localparam int WORD_BITS   = 16;
   localparam int RETRY_ROW_W = WORD_BITS * RETRY_W;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [ACTION_W-1:0] ACT_START   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_VALUE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CANCEL  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_LIST_REQ  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_READ_REQ  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FAILED    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd6;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT     = 2'd2;

   localparam logic [TIMEOUT_W-1:0] IDLE_DEFAULT    = 16'd500;
   localparam logic [TIMEOUT_W-1:0] REQUEST_DEFAULT = 16'd3000;
   localparam logic [RETRY_W-1:0]   RETRY_DEFAULT   = 4'd3;
   localparam logic [RETRY_W-1:0]   RETRY_MAX       = 4'd15;

   typedef struct packed {
      logic [ACTION_W-1:0] kind;
      logic                in_range;
      logic [PARAM_W-1:0]  pidx;
      logic [PARAM_W-1:0]  pcnt;
   } cmd_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] idle_wait;
      logic [TIMEOUT_W-1:0] req_wait;
      logic [RETRY_W-1:0]   retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [INDEX_OUT_W-1:0] index_out;
      logic [SEEN_OUT_W-1:0]  seen_total;
      logic [EXPECTED_W-1:0]  exp_total;
      logic                   count_known;
      logic [TIMEOUT_W-1:0]   next_wait_ms;
   } result_type;

endpackage

// ===== hw/rtl/plft_front.sv =====
// ----------------------------------------------------------------------------
// plft_front
// Accepts request words, classifies them and pushes commands to the queue.
// ----------------------------------------------------------------------------
module plft_front #(
   parameter int INDEX_SLOTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [plft_pkg::ACTION_W-1:0]       req_tuser,
   input  logic [2*plft_pkg::PARAM_W-1:0]      req_tdata,
   input  logic                                q_full,
   input  logic                                clearing,
   output logic                                push,
   output plft_pkg::cmd_type                   cmd
);
   import plft_pkg::*;

   localparam int CMP_W = PARAM_W + 2;
   localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(INDEX_SLOTS);

   logic hold_ff;
   logic hold_in;

   // hold off out of reset and while the back end runs its clear pass
   assign hold_in    = 1'b0;
   assign req_tready = !q_full && !clearing && !hold_ff;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      cmd.kind     = req_tuser;
      cmd.pidx     = req_tdata[PARAM_W-1:0];
      cmd.pcnt     = req_tdata[2*PARAM_W-1:PARAM_W];
      cmd.in_range = CMP_W'(req_tdata[PARAM_W-1:0]) < SLOTS_C;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b1;
      end else begin
         hold_ff <= hold_in;
      end
   end

endmodule

// ===== hw/rtl/plft_queue.sv =====
// ----------------------------------------------------------------------------
// plft_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module plft_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  plft_pkg::cmd_type cmd_in,
   input  logic              pop,
   output plft_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);
   import plft_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ===== hw/rtl/plft_back.sv =====
// ----------------------------------------------------------------------------
// plft_back
// Download sequencer: seen map and retry rows, missing-index scan, result
// register.
// ----------------------------------------------------------------------------
module plft_back #(
   parameter int INDEX_SLOTS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  plft_pkg::cmd_type    head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 clearing,
   input  plft_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output plft_pkg::result_type rsp
);
   import plft_pkg::*;

   localparam int ROWS   = (INDEX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = $clog2(WORD_BITS);
   localparam int IDX_W  = ROW_W + COL_W;
   localparam int CNT_W  = $clog2(INDEX_SLOTS + 1);
   localparam int MAX_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam int WIDE_W = ((MAX_W > EXPECTED_W) ? MAX_W : EXPECTED_W) + 1;
   localparam logic [WIDE_W-1:0] SLOTS_C = WIDE_W'(INDEX_SLOTS);
   localparam logic [WIDE_W-1:0] WORD_C  = WIDE_W'(WORD_BITS);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] S_CLEAR = 3'd0;
   localparam logic [STATE_W-1:0] S_IDLE  = 3'd1;
   localparam logic [STATE_W-1:0] S_VRD   = 3'd2;
   localparam logic [STATE_W-1:0] S_SCAN  = 3'd3;
   localparam logic [STATE_W-1:0] S_EMIT  = 3'd4;

   logic [WORD_BITS-1:0]   seen_mem  [ROWS];
   logic [RETRY_ROW_W-1:0] retry_mem [ROWS];

   logic [STATE_W-1:0]    state_ff, state_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [EXPECTED_W-1:0] exp_ff, exp_in;
   logic                  known_ff, known_in;
   logic                  retrying_ff, retrying_in;
   logic                  running_ff, running_in;
   logic                  clr_pend_ff, clr_pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [COL_W-1:0]      col_ff, col_in;
   logic [PARAM_W-1:0]    vcount_ff, vcount_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   result_type            rsp_ff, rsp_in;

   logic [WORD_BITS-1:0]   seen_rd_ff;
   logic [RETRY_ROW_W-1:0] retry_rd_ff;
   logic                   seen_we, retry_we;
   logic [WORD_BITS-1:0]   seen_wd;
   logic [RETRY_ROW_W-1:0] retry_wd;
   logic [ROW_W-1:0]       rd_row;

   logic [ROW_W-1:0]       head_row;
   logic [COL_W-1:0]       head_col;
   logic [WIDE_W-1:0]      bound, base, rem;
   logic [WORD_BITS-1:0]   mask, miss;
   logic                   found, last_row;
   logic [COL_W-1:0]       pos;
   logic [RETRY_W-1:0]     nib, nib_inc;
   logic [RETRY_ROW_W-1:0] retry_bump;
   logic [CNT_W-1:0]       cnt_next;
   logic [EXPECTED_W-1:0]  exp_next;
   logic [TIMEOUT_W-1:0]   idle_eff, req_eff;

   assign head_row = ROW_W'(head.pidx >> COL_W);
   assign head_col = head.pidx[COL_W-1:0];

   assign clearing  = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign idle_eff = (cfg.idle_wait == '0) ? IDLE_DEFAULT : cfg.idle_wait;
   assign req_eff  = (cfg.req_wait == '0) ? REQUEST_DEFAULT : cfg.req_wait;

   // missing-index search over the row currently read
   always_comb begin
      bound = (WIDE_W'(exp_ff) < SLOTS_C) ? WIDE_W'(exp_ff) : SLOTS_C;
      base  = WIDE_W'({row_ff, {COL_W{1'b0}}});
      rem   = bound - base;
      for (int b = 0; b < WORD_BITS; b++) begin
         mask[b] = rem > WIDE_W'(b);
      end
      miss     = ~seen_rd_ff & mask;
      found    = |miss;
      last_row = rem <= WORD_C;
      pos      = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (miss[b]) begin
            pos = COL_W'(b);
         end
      end
      nib     = retry_rd_ff[pos*RETRY_W +: RETRY_W];
      nib_inc = (nib == RETRY_MAX) ? nib : RETRY_W'(nib + 1'b1);
      for (int b = 0; b < WORD_BITS; b++) begin
         retry_bump[b*RETRY_W +: RETRY_W] =
            (COL_W'(b) == pos) ? nib_inc : retry_rd_ff[b*RETRY_W +: RETRY_W];
      end
   end

   assign cnt_next = CNT_W'(cnt_ff + 1'b1);
   assign exp_next = known_ff ? exp_ff : vcount_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      exp_in       = exp_ff;
      known_in     = known_ff;
      retrying_in  = retrying_ff;
      running_in   = running_ff;
      clr_pend_in  = clr_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      col_in       = col_ff;
      vcount_in    = vcount_ff;
      status_in    = status_ff;
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      seen_we      = 1'b0;
      retry_we     = 1'b0;
      seen_wd      = seen_rd_ff;
      retry_wd     = retry_bump;
      rd_row       = row_ff;

      case (state_ff)
         S_CLEAR: begin
            seen_we  = 1'b1;
            retry_we = 1'b1;
            seen_wd  = '0;
            retry_wd = '0;
            if (row_ff == LAST_ROW) begin
               row_in   = '0;
               state_in = S_IDLE;
            end else begin
               row_in = ROW_W'(row_ff + 1'b1);
            end
         end
         S_IDLE: begin
            rd_row = (head.kind == ACT_TIMEOUT) ? '0 : head_row;
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = S_EMIT;
               idx_in   = '0;
               case (head.kind)
                  ACT_START: begin
                     cnt_in      = '0;
                     exp_in      = '0;
                     known_in    = 1'b0;
                     retrying_in = 1'b0;
                     running_in  = 1'b1;
                     clr_pend_in = 1'b1;
                     status_in   = ST_LIST_REQ;
                  end
                  ACT_VALUE: begin
                     if (!running_ff) begin
                        status_in = ST_IGNORED;
                     end else if (!head.in_range) begin
                        status_in = ST_DROPPED;
                     end else begin
                        row_in    = head_row;
                        col_in    = head_col;
                        vcount_in = head.pcnt;
                        state_in  = S_VRD;
                     end
                  end
                  ACT_TIMEOUT: begin
                     if (!running_ff) begin
                        status_in = ST_IGNORED;
                     end else if (!known_ff) begin
                        running_in = 1'b0;
                        status_in  = ST_FAILED;
                     end else if (exp_ff == '0) begin
                        running_in = 1'b0;
                        status_in  = ST_COMPLETE;
                     end else begin
                        row_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     if (!running_ff) begin
                        status_in = ST_IGNORED;
                     end else begin
                        running_in = 1'b0;
                        status_in  = ST_CANCELLED;
                     end
                  end
               endcase
            end
         end
         S_VRD: begin
            state_in = S_EMIT;
            idx_in   = {row_ff, col_ff};
            if (seen_rd_ff[col_ff]) begin
               status_in = ST_DROPPED;
               idx_in    = '0;
            end else begin
               seen_we          = 1'b1;
               seen_wd[col_ff]  = 1'b1;
               cnt_in           = cnt_next;
               exp_in           = exp_next;
               known_in         = 1'b1;
               retrying_in      = 1'b0;
               if (WIDE_W'(cnt_next) >= WIDE_W'(exp_next)) begin
                  running_in = 1'b0;
                  status_in  = ST_COMPLETE;
               end else begin
                  status_in = ST_ACCEPTED;
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               state_in = S_EMIT;
               idx_in   = {row_ff, pos};
               if (nib >= cfg.retry_limit) begin
                  running_in = 1'b0;
                  status_in  = ST_FAILED;
               end else begin
                  retry_we    = 1'b1;
                  retrying_in = 1'b1;
                  status_in   = ST_READ_REQ;
               end
            end else if (last_row) begin
               state_in   = S_EMIT;
               idx_in     = '0;
               running_in = 1'b0;
               status_in  = ST_COMPLETE;
            end else begin
               row_in = ROW_W'(row_ff + 1'b1);
               rd_row = ROW_W'(row_ff + 1'b1);
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.index_out      = INDEX_OUT_W'(idx_ff);
               rsp_in.seen_total     = SEEN_OUT_W'(cnt_ff);
               rsp_in.exp_total      = exp_ff;
               rsp_in.count_known    = known_ff;
               rsp_in.next_wait_ms   = (!known_ff || retrying_ff) ? req_eff : idle_eff;
               row_in                = '0;
               clr_pend_in           = 1'b0;
               state_in              = clr_pend_ff ? S_CLEAR : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         cnt_ff       <= '0;
         exp_ff       <= '0;
         known_ff     <= 1'b0;
         retrying_ff  <= 1'b0;
         running_ff   <= 1'b0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         exp_ff       <= exp_in;
         known_ff     <= known_in;
         retrying_ff  <= retrying_in;
         running_ff   <= running_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      vcount_ff <= vcount_in;
      status_ff <= status_in;
      idx_ff    <= idx_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[row_ff] <= seen_wd;
      end
      if (retry_we) begin
         retry_mem[row_ff] <= retry_wd;
      end
      seen_rd_ff  <= seen_mem[rd_row];
      retry_rd_ff <= retry_mem[rd_row];
   end

endmodule

// ===== hw/rtl/param_list_fetch_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// param_list_fetch_tracker_unit
// Client-side tracker of a parameter list download with per-index retry.
//
// req_ carries one action word (start, value arrived, wait timed out,
// cancel); rsp_ returns exactly one result word for each action word.
// csr_ writes the idle timeout, request timeout and retry limit registers.
// A front end classifies action words into a two-entry command queue; a
// sequencer keeps the seen map and retry counters in memories of
// WORD_BITS slots per row and emits each result into an output register.
// Cancel, ignored and out-of-range words go straight to the result register; an
// in-range value word first reads its seen row, a timeout scans up to
// INDEX_SLOTS/16 rows, and a start's clear pass sweeps both memories one row
// per cycle. After reset the same clear pass runs with req_tready low; csr_
// writes are taken at any time.
// A stalled rsp_ side holds the result register; up to two more words are
// queued before req_tready drops.
// ----------------------------------------------------------------------------
module param_list_fetch_tracker_unit #(
   parameter int INDEX_SLOTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [plft_pkg::ACTION_W-1:0]     req_tuser,  // action
   input  logic [31:0]                       req_tdata,  // parameter index, parameter count
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [plft_pkg::STATUS_W-1:0]     rsp_tuser,  // status
   // index_out, seen total, expected total, count_known, next_wait_ms, zero pad
   output logic [55:0]                       rsp_tdata,
   input  logic                              csr_wen,
   input  logic [plft_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [plft_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import plft_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd, head;
   result_type rsp;
   logic       push, pop, q_empty, q_full, clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_IDLE_TIMEOUT:    cfg_in.idle_wait   = csr_wdata;
            CSR_REQUEST_TIMEOUT: cfg_in.req_wait    = csr_wdata;
            CSR_RETRY_LIMIT:     cfg_in.retry_limit = csr_wdata[RETRY_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_wait   <= IDLE_DEFAULT;
         cfg_ff.req_wait    <= REQUEST_DEFAULT;
         cfg_ff.retry_limit <= RETRY_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   plft_front #(
      .INDEX_SLOTS (INDEX_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push),
      .cmd        (cmd)
   );

   plft_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .cmd_in (cmd),
      .pop    (pop),
      .head   (head),
      .empty  (q_empty),
      .full   (q_full)
   );

   plft_back #(
      .INDEX_SLOTS (INDEX_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (pop),
      .clearing  (clearing),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.next_wait_ms, rsp.count_known,
                       rsp.exp_total, rsp.seen_total, rsp.index_out};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the parameter list fetch tracker.
//
// Action words go in on req_ and one result word per action comes back on
// rsp_. An in-bench tracker with its own seen map and retry counters
// predicts every result; a short table of directed words comes first.
// After that, random downloads run under seven register settings. These
// cover the extremes, zero timeouts and retry limits of 0 and 15, and
// totals above the slot count. Both sides idle at random, the receiver
// stalls once long enough to back up the block, and a watchdog ends a
// hung run.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import plft_pkg::*;

   localparam int SLOTS          = 1024;
   localparam int HALF_PERIOD    = 5;
   localparam int QUIET_LIMIT    = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int PHASES         = 7;
   localparam int PHASE_WORDS    = 145;
   localparam int SETTLE_CYCLES  = 100;

   typedef struct {
      logic [ACTION_W-1:0] act;
      logic [PARAM_W-1:0]  pidx;
      logic [PARAM_W-1:0]  pcnt;
      bit                  fixed;
      result_type          want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ACTION_W-1:0]   req_tuser = '0;   // action
   logic [31:0]           req_tdata = '0;   // parameter index, parameter count
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [STATUS_W-1:0]   rsp_tuser;        // status
   // index_out, seen total, expected total, count_known, next_wait_ms, zero pad
   logic [55:0]           rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // tracker copy of the block
   bit                    slot_seen [SLOTS];
   logic [RETRY_W-1:0]    slot_tries [SLOTS];
   int                    got_n;
   logic [EXPECTED_W-1:0] want_n;
   bit                    want_known;
   bit                    chasing;
   bit                    active;
   logic [TIMEOUT_W-1:0]  idle_ms;
   logic [TIMEOUT_W-1:0]  req_ms;
   logic [RETRY_W-1:0]    try_cap;

   result_type            outcomes_due [$];
   stim_row_type          directed_rows [$];
   bit                    req_gaps = 1'b1;
   bit                    rsp_gaps = 1'b1;
   bit                    hold_request = 1'b0;
   int                    fail_count = 0;
   int                    words_sent = 0;
   int                    scored_words = 0;
   int                    results_checked = 0;
   int                    downloads = 0;
   int                    status_tally [8];
   int                    quiet = 0;

   param_list_fetch_tracker_unit #(.INDEX_SLOTS(SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = ~clock;
   end

   // cycles with no word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
         $display("tb_top: watchdog expired after %0d idle cycles", quiet);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 40) begin
         $display("tb_top: mismatch at %0t: %s", $realtime, what);
      end
   endtask

   task automatic cmp_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   function automatic void clear_download();
      for (int k = 0; k < SLOTS; k++) begin
         slot_seen[k] = 1'b0;
         slot_tries[k] = '0;
      end
      got_n = 0;
      want_n = '0;
      want_known = 1'b0;
      chasing = 1'b0;
   endfunction

   function automatic result_type fetch_outcome(input logic [ACTION_W-1:0] act,
                                                input logic [PARAM_W-1:0] pidx,
                                                input logic [PARAM_W-1:0] pcnt);
      result_type r;
      int bound;
      int miss;
      r = '0;
      r.status = ST_IGNORED;
      if (act == ACT_START) begin
         clear_download();
         active = 1'b1;
         r.status = ST_LIST_REQ;
      end else if (!active) begin
         r.status = ST_IGNORED;
      end else if (act == ACT_VALUE) begin
         if (pidx >= SLOTS || slot_seen[pidx]) begin
            r.status = ST_DROPPED;
         end else begin
            slot_seen[pidx] = 1'b1;
            got_n++;
            chasing = 1'b0;
            if (!want_known) begin
               want_n = pcnt;
               want_known = 1'b1;
            end
            r.index_out = pidx[INDEX_OUT_W-1:0];
            if (got_n >= want_n) begin
               active = 1'b0;
               r.status = ST_COMPLETE;
            end else begin
               r.status = ST_ACCEPTED;
            end
         end
      end else if (act == ACT_TIMEOUT) begin
         if (!want_known) begin
            active = 1'b0;
            r.status = ST_FAILED;
         end else begin
            bound = (want_n < SLOTS) ? int'(want_n) : SLOTS;
            miss = 0;
            while (miss < bound && slot_seen[miss]) miss++;
            if (miss == bound) begin
               active = 1'b0;
               r.status = ST_COMPLETE;
            end else if (slot_tries[miss] >= try_cap) begin
               active = 1'b0;
               r.status = ST_FAILED;
               r.index_out = 10'(miss);
            end else begin
               if (slot_tries[miss] < RETRY_MAX) slot_tries[miss]++;
               chasing = 1'b1;
               r.status = ST_READ_REQ;
               r.index_out = 10'(miss);
            end
         end
      end else begin
         active = 1'b0;
         r.status = ST_CANCELLED;
      end
      r.seen_total = 11'(got_n);
      r.exp_total = want_n;
      r.count_known = want_known;
      if (!want_known || chasing) begin
         r.next_wait_ms = (req_ms != 0) ? req_ms : REQUEST_DEFAULT;
      end else begin
         r.next_wait_ms = (idle_ms != 0) ? idle_ms : IDLE_DEFAULT;
      end
      return r;
   endfunction

   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic [PARAM_W-1:0] pidx,
                            input logic [PARAM_W-1:0] pcnt,
                            input bit fixed = 1'b0,
                            input result_type want = '0);
      int gap;
      result_type guess;
      gap = req_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {pcnt, pidx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      guess = fetch_outcome(act, pidx, pcnt);
      outcomes_due.push_back(fixed ? want : guess);
      words_sent++;
      if (guess.status != ST_IGNORED) scored_words++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outcomes_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] idle_v, input logic [15:0] req_v,
                               input logic [15:0] retry_v);
      csr_wen <= 1'b1;
      csr_index <= CSR_IDLE_TIMEOUT;
      csr_wdata <= idle_v;
      @(posedge clock);
      csr_index <= CSR_REQUEST_TIMEOUT;
      csr_wdata <= req_v;
      @(posedge clock);
      csr_index <= CSR_RETRY_LIMIT;
      csr_wdata <= retry_v;
      @(posedge clock);
      csr_wen <= 1'b0;
      idle_ms = idle_v;
      req_ms = req_v;
      try_cap = retry_v[RETRY_W-1:0];
   endtask

   task automatic add_row(input logic [ACTION_W-1:0] act, input logic [15:0] pidx,
                          input logic [15:0] pcnt, input bit fixed = 1'b0,
                          input logic [STATUS_W-1:0] st = '0, input int io = 0,
                          input int seen = 0, input int exp_n = 0, input bit known = 1'b0,
                          input int wait_ms = 0);
      stim_row_type row;
      row.act = act;
      row.pidx = pidx;
      row.pcnt = pcnt;
      row.fixed = fixed;
      row.want.status = st;
      row.want.index_out = 10'(io);
      row.want.seen_total = 11'(seen);
      row.want.exp_total = 16'(exp_n);
      row.want.count_known = known;
      row.want.next_wait_ms = 16'(wait_ms);
      directed_rows.push_back(row);
   endtask

   task automatic run_download();
      int plan;
      int lim;
      int steps;
      int roll;
      int guard;
      bit burst;
      logic [ACTION_W-1:0] act;
      logic [PARAM_W-1:0] pidx;
      logic [PARAM_W-1:0] pcnt;
      roll = $urandom_range(0, 99);
      if (roll < 8) plan = 0;
      else if (roll < 14) plan = $urandom_range(SLOTS, 65535);
      else if (roll < 20) plan = 1;
      else plan = $urandom_range(2, 40);
      lim = (plan >= SLOTS) ? SLOTS - 1 : plan + 1;
      burst = ($urandom_range(0, 3) == 0);
      req_gaps = ($urandom_range(0, 3) != 0);
      rsp_gaps = ($urandom_range(0, 3) != 0);
      downloads++;
      send_word(ACT_START, 16'($urandom), 16'($urandom));
      steps = 0;
      while (active && steps < 60) begin
         steps++;
         roll = $urandom_range(0, 99);
         if (roll < 3) act = ACT_CANCEL;
         else if (roll < 5) act = ACT_START;
         else if (roll < (burst ? 70 : 35) && (want_known || roll < 7)) act = ACT_TIMEOUT;
         else act = ACT_VALUE;
         if (act == ACT_VALUE) begin
            pidx = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(SLOTS, 65535))
                                               : 16'($urandom_range(0, lim));
            pcnt = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(plan);
         end else begin
            pidx = 16'($urandom);
            pcnt = 16'($urandom);
         end
         send_word(act, pidx, pcnt);
      end
      // run the missing index out of retries
      guard = 0;
      while (burst && active && want_known && guard < 20) begin
         guard++;
         send_word(ACT_TIMEOUT, 16'($urandom), 16'($urandom));
      end
      if (!active && $urandom_range(0, 3) == 0) begin
         send_word(ACT_VALUE, 16'($urandom), 16'($urandom));
         send_word(($urandom_range(0, 1) != 0) ? ACT_TIMEOUT : ACT_CANCEL,
                   16'($urandom), 16'($urandom));
      end
   endtask

   task automatic load_directed();
      add_row(ACT_VALUE, 16'd5, 16'd1, 1, ST_IGNORED, 0, 0, 0, 0, 3000);
      add_row(ACT_TIMEOUT, 16'hFFFF, 16'hFFFF, 1, ST_IGNORED, 0, 0, 0, 0, 3000);
      add_row(ACT_CANCEL, 16'h0, 16'h0, 1, ST_IGNORED, 0, 0, 0, 0, 3000);
      add_row(ACT_START, 16'hFFFF, 16'hFFFF, 1, ST_LIST_REQ, 0, 0, 0, 0, 3000);
      add_row(ACT_TIMEOUT, 16'd0, 16'd0, 1, ST_FAILED, 0, 0, 0, 0, 3000);
      add_row(ACT_START, 16'd0, 16'd0, 1, ST_LIST_REQ, 0, 0, 0, 0, 3000);
      add_row(ACT_VALUE, 16'hFFFF, 16'hFFFF, 1, ST_DROPPED, 0, 0, 0, 0, 3000);
      add_row(ACT_VALUE, 16'd1024, 16'd7, 1, ST_DROPPED, 0, 0, 0, 0, 3000);
      add_row(ACT_VALUE, 16'd1023, 16'd5, 1, ST_ACCEPTED, 1023, 1, 5, 1, 500);
      add_row(ACT_VALUE, 16'd1023, 16'd5, 1, ST_DROPPED, 0, 1, 5, 1, 500);
      add_row(ACT_VALUE, 16'd0, 16'hFFFF);
      add_row(ACT_TIMEOUT, 16'd0, 16'd0, 1, ST_READ_REQ, 1, 2, 5, 1, 3000);
      add_row(ACT_TIMEOUT, 16'd0, 16'd0);
      add_row(ACT_TIMEOUT, 16'd0, 16'd0);
      add_row(ACT_TIMEOUT, 16'd0, 16'd0, 1, ST_FAILED, 1, 2, 5, 1, 3000);
      add_row(ACT_START, 16'd0, 16'd0);
      add_row(ACT_VALUE, 16'd2, 16'd0, 1, ST_COMPLETE, 2, 1, 0, 1, 500);
      add_row(ACT_START, 16'd0, 16'd0);
      add_row(ACT_VALUE, 16'd3, 16'd3);
      add_row(ACT_START, 16'd0, 16'd0);
      add_row(ACT_VALUE, 16'd0, 16'd2);
      add_row(ACT_VALUE, 16'd1, 16'd9);
      add_row(ACT_START, 16'd0, 16'd0);
      add_row(ACT_VALUE, 16'd7, 16'h8000);
      add_row(ACT_CANCEL, 16'hFFFF, 16'hFFFF);
   endtask

   // result side: random gaps, one long hold on request
   initial begin : rsp_side
      int gap;
      logic [STATUS_W-1:0] got_status;
      logic [55:0] got_data;
      result_type want;
      forever begin
         gap = rsp_gaps ? $urandom_range(0, 4) : 0;
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         got_status = rsp_tuser;
         got_data = rsp_tdata;
         status_tally[got_status]++;
         if (outcomes_due.size() == 0) begin
            report_mismatch($sformatf("result word with nothing pending, status %0d",
                                      got_status));
         end else begin
            want = outcomes_due.pop_front();
            results_checked++;
            cmp_field("status", got_status, want.status);
            cmp_field("index_out", got_data[9:0], want.index_out);
            cmp_field("seen total", got_data[20:10], want.seen_total);
            cmp_field("expected total", got_data[36:21], want.exp_total);
            cmp_field("count_known", got_data[37], want.count_known);
            cmp_field("next_wait_ms", got_data[53:38], want.next_wait_ms);
         end
      end
   end

   initial begin : stimulus
      int ph;
      int base;
      int dl;
      logic [15:0] idle_v;
      logic [15:0] req_v;
      logic [15:0] retry_v;
      foreach (status_tally[s]) status_tally[s] = 0;
      clear_download();
      active = 1'b0;
      idle_ms = IDLE_DEFAULT;
      req_ms = REQUEST_DEFAULT;
      try_cap = RETRY_DEFAULT;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      load_directed();
      foreach (directed_rows[k]) begin
         send_word(directed_rows[k].act, directed_rows[k].pidx, directed_rows[k].pcnt,
                   directed_rows[k].fixed, directed_rows[k].want);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         drain_results();
         case (ph)
            0: begin idle_v = 16'd1; req_v = 16'hFFFF; retry_v = 16'd0; end
            1: begin idle_v = 16'hFFFF; req_v = 16'd1; retry_v = 16'hFFFF; end
            2: begin idle_v = 16'd0; req_v = 16'd0; retry_v = 16'd1; end
            default: begin
               idle_v = 16'($urandom);
               req_v = 16'($urandom);
               retry_v = 16'($urandom);
            end
         endcase
         write_config(idle_v, req_v, retry_v);
         base = scored_words;
         dl = 0;
         while (scored_words - base < PHASE_WORDS) begin
            run_download();
            dl++;
            if (ph == 0 && dl == 10) hold_request = 1'b1;
            if (dl % 40 == 0) drain_results();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("tb_top: %0d words sent, %0d results checked, %0d downloads, 7 settings",
               words_sent, results_checked, downloads);
      $display("tb_top: by status list/acc/drop/read/done/fail/cancel/ign %0d %0d %0d %0d %0d %0d %0d %0d",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4], status_tally[5], status_tally[6], status_tally[7]);
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
